FILE: hdl/etl_pkg.sv
// Shared types for the expression token lexer.
// Holds the scan mode and token kind encodings and the token record.
// Used by etl_scan, etl_token_queue and expression_token_lexer_core.
package etl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    TOK_PLUS  = 4'd0,
    TOK_MINUS = 4'd1,
    TOK_MUL   = 4'd2,
    TOK_DIV   = 4'd3,
    TOK_OPEN  = 4'd4,
    TOK_CLOSE = 4'd5,
    TOK_INT   = 4'd6,
    TOK_DIM   = 4'd7,
    TOK_AS    = 4'd8,
    TOK_IDENT = 4'd9,
    TOK_ERROR = 4'd10,
    TOK_END   = 4'd11
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [30:0] int_value;
    logic [63:0] ident_text;
    logic [7:0]  ident_length;
    logic        last;
  } token_t;

  // Tokens caused by one accepted byte: tok0 comes first, count says how many are real.
  typedef struct packed {
    token_t     tok0;
    token_t     tok1;
    logic [1:0] count;
  } scan_result_t;

endpackage

FILE: hdl/etl_scan.sv
// Lexer step: classifies one byte, keeps the pending number or identifier,
// and produces the zero, one or two tokens that the byte causes.
// Depends on etl_pkg.
module etl_scan #(
  parameter int IDENT_KEEP_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            char_code,
  input  logic                  end_of_text,
  output etl_pkg::scan_result_t result
);

  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_STAR  = 8'h2A;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_OPEN  = 8'h28;
  localparam logic [7:0]  CH_CLOSE = 8'h29;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [63:0] KW_DIM   = 64'h0000_0000_006D_6964;
  localparam logic [63:0] KW_AS    = 64'h0000_0000_0000_7361;
  localparam logic [30:0] INT_MAX  = '1;

  etl_pkg::scan_mode_t mode, mode_next;
  logic [30:0] acc, acc_next;
  logic [63:0] ident_bytes, ident_bytes_next;
  logic [7:0]  ident_count, ident_count_next;

  logic is_digit, is_letter, is_space, pend_valid, cont_num, cont_ident;
  logic [34:0] acc_sum;
  logic [30:0] acc_step;
  logic [63:0] bytes_step;
  logic [63:0] keep_mask;
  etl_pkg::token_t pend_tok, second_tok;
  logic second_valid;
  logic [1:0] count;

  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                     ((char_code >= 8'h41) && (char_code <= 8'h5A));
  assign is_space  = ((char_code >= 8'h09) && (char_code <= 8'h0D)) || (char_code == CH_SPACE);

  assign pend_valid = (mode == etl_pkg::MODE_NUM) || (mode == etl_pkg::MODE_IDENT);
  assign cont_num   = !end_of_text && (mode == etl_pkg::MODE_NUM) && is_digit;
  assign cont_ident = !end_of_text && (mode == etl_pkg::MODE_IDENT) && (is_letter || is_digit);

  // Multiply by ten as two shifted copies; the sum cannot exceed 35 bits.
  assign acc_sum  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, char_code[3:0]};
  assign acc_step = (acc_sum[34:31] != 4'd0) ? INT_MAX : acc_sum[30:0];

  always_comb begin
    bytes_step = ident_bytes;
    for (int i = 0; i < 8; i++) begin
      if ((ident_count < 8'd8) && (ident_count[2:0] == 3'(i))) begin
        bytes_step[8*i +: 8] = char_code;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep_mask[8*i +: 8] = (i < IDENT_KEEP_BYTES) ? 8'hFF : 8'h00;
    end
  end

  // Next state.
  always_comb begin
    mode_next        = mode;
    acc_next         = acc;
    ident_bytes_next = ident_bytes;
    ident_count_next = ident_count;
    if (fire) begin
      if (cont_num) begin
        acc_next = acc_step;
      end else if (cont_ident) begin
        ident_bytes_next = bytes_step;
        if (ident_count != 8'hFF) begin
          ident_count_next = ident_count + 8'd1;
        end
      end else begin
        mode_next        = etl_pkg::MODE_IDLE;
        acc_next         = '0;
        ident_bytes_next = '0;
        ident_count_next = '0;
        if (!end_of_text && is_digit) begin
          mode_next = etl_pkg::MODE_NUM;
          acc_next  = {27'd0, char_code[3:0]};
        end else if (!end_of_text && is_letter) begin
          mode_next        = etl_pkg::MODE_IDENT;
          ident_bytes_next = {56'd0, char_code};
          ident_count_next = 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= etl_pkg::MODE_IDLE;
      acc         <= '0;
      ident_bytes <= '0;
      ident_count <= '0;
    end else begin
      mode        <= mode_next;
      acc         <= acc_next;
      ident_bytes <= ident_bytes_next;
      ident_count <= ident_count_next;
    end
  end

  // Token outputs.
  always_comb begin
    pend_tok = '0;
    if (mode == etl_pkg::MODE_NUM) begin
      pend_tok.kind      = etl_pkg::TOK_INT;
      pend_tok.int_value = acc;
    end else begin
      // Keywords are matched on the full eight bytes, independent of the kept width.
      if ((ident_count == 8'd3) && (ident_bytes == KW_DIM)) begin
        pend_tok.kind = etl_pkg::TOK_DIM;
      end else if ((ident_count == 8'd2) && (ident_bytes == KW_AS)) begin
        pend_tok.kind = etl_pkg::TOK_AS;
      end else begin
        pend_tok.kind = etl_pkg::TOK_IDENT;
      end
      pend_tok.ident_text   = ident_bytes & keep_mask;
      pend_tok.ident_length = ident_count;
    end
  end

  always_comb begin
    second_tok      = '0;
    second_tok.last = 1'b1;
    second_valid    = 1'b0;
    if (end_of_text) begin
      second_tok.kind = etl_pkg::TOK_END;
      second_valid    = 1'b1;
    end else if (!(is_space || is_digit || is_letter)) begin
      second_valid = 1'b1;
      unique case (char_code)
        CH_PLUS:  second_tok.kind = etl_pkg::TOK_PLUS;
        CH_MINUS: second_tok.kind = etl_pkg::TOK_MINUS;
        CH_STAR:  second_tok.kind = etl_pkg::TOK_MUL;
        CH_SLASH: second_tok.kind = etl_pkg::TOK_DIV;
        CH_OPEN:  second_tok.kind = etl_pkg::TOK_OPEN;
        CH_CLOSE: second_tok.kind = etl_pkg::TOK_CLOSE;
        default:  second_tok.kind = etl_pkg::TOK_ERROR;
      endcase
    end
  end

  always_comb begin
    result = '0;
    count  = 2'd0;
    if (!(cont_num || cont_ident)) begin
      count = 2'(pend_valid) + 2'(second_valid);
    end
    if (pend_valid) begin
      result.tok0      = pend_tok;
      result.tok0.last = !second_valid;
      result.tok1      = second_tok;
    end else begin
      result.tok0 = second_tok;
    end
    result.count = fire ? count : 2'd0;
  end

  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_text) |=> (mode == etl_pkg::MODE_IDLE))
    else $error("scan mode not idle after end of text");

  a_two_last: assert property (@(posedge clk) disable iff (rst)
    (result.count == 2'd2) |-> (!result.tok0.last && result.tok1.last))
    else $error("last flag misplaced on a pair of tokens");

  a_cont_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && (cont_num || cont_ident)) |-> (result.count == 2'd0))
    else $error("token emitted while extending a pending token");

endmodule

FILE: hdl/etl_token_queue.sv
// Small token queue between the lexer step and the output stream.
// Takes up to two tokens a cycle and hands out one while head_ready is high; depends on etl_pkg.
module etl_token_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  etl_pkg::scan_result_t push,
  output logic                  room,
  output etl_pkg::token_t       head,
  output logic                  head_valid,
  input  logic                  head_ready
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  etl_pkg::token_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign room       = count <= CntW'(Depth - 2);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PtrW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> ((count + CntW'(push.count)) <= CntW'(Depth)))
    else $error("token queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("token queue count out of range");

endmodule

FILE: hdl/expression_token_lexer_core.sv
// Top level of the expression token lexer: byte stream in, token stream out.
// Instantiates etl_scan and etl_token_queue; depends on etl_pkg.
//
// Takes one source byte per transaction (or an end-of-text marker in s_tuser) and
// emits one token per output transaction, with m_tlast on the final token that a
// byte causes. A byte is accepted in every cycle while the four-entry token queue
// has two free places, and its tokens are queued from the cycle after acceptance.
// A byte gives zero, one or two tokens; the output side moves one token per cycle
// while m_tready is high, so a run of bytes that each give two tokens is held back
// by the output side. Identifier text is kept to IDENT_KEEP_BYTES bytes (2 to 8).
module expression_token_lexer_core #(
  parameter int IDENT_KEEP_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_code
  input  logic [0:0]   s_tuser,   // [0] end_of_text
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [30:0] int_value, [94:31] ident_text,
                                  // [102:95] ident_length, [103] zero
  output logic [3:0]   m_tuser,   // [3:0] token_kind
  output logic         m_tlast
);

  logic                  fire;
  etl_pkg::scan_result_t scan_out;
  etl_pkg::token_t       head;

  assign fire = s_tvalid && s_tready;

  etl_scan #(
    .IDENT_KEEP_BYTES(IDENT_KEEP_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .char_code   (s_tdata),
    .end_of_text (s_tuser[0]),
    .result      (scan_out)
  );

  etl_token_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (scan_out),
    .room       (s_tready),
    .head       (head),
    .head_valid (m_tvalid),
    .head_ready (m_tready)
  );

  assign m_tdata = {1'b0, head.ident_length, head.ident_text, head.int_value};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
